/* hdl/lcg_ris_pkg.sv */
// ============================================================================
// LCG random index sampler package
// Shared constants and types for the sampler and its remainder unit.
// ============================================================================
`default_nettype none

package lcg_ris_pkg;

   // Generator arithmetic
   localparam int unsigned WORD_W = 32;
   localparam int unsigned BOUND_W = 64;
   localparam logic [WORD_W-1:0] LCG_INCREMENT = 32'd12345;
   localparam logic [WORD_W-1:0] LCG_MULTIPLIER = 32'd1103515245;

   // Remainder unit: one dividend bit per cycle
   localparam int unsigned DIV_STEPS = WORD_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // Stream payload widths (padded to whole bytes)
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 72;
   localparam int unsigned RSP_PAD_W = RSP_DATA_W - (2 * WORD_W + 1);

   // Control and status between the sequencer and the remainder unit
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

/* hdl/lcg_random_index_sampler_top.sv */
// ============================================================================
// LCG random index sampler
// Advances a 32-bit generator per request with a nonzero bound and reduces the draw modulo the bound.
// ============================================================================
// Path to the result register: a zero bound goes from acceptance straight to
// the hand-off state; a bound of 2^32 or more passes the multiply state; any
// other bound also waits on the 32-step serial remainder unit. One item is in
// work at a time. A new item is accepted while a finished result waits.
// Synchronous reset clears the generator state to 0.
`default_nettype none

module lcg_random_index_sampler_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Configuration: seed write
   input  wire logic                                  csr_we,
   input  wire logic [lcg_ris_pkg::WORD_W-1:0]         csr_wdata,
   // Request stream
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   input  wire logic [lcg_ris_pkg::REQ_DATA_W-1:0]     req_tdata,   // [63:0] bound
   // Response stream
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [31:0] raw_value, [63:32] index_value, [64] one_in_n_hit, [71:65] zero pad
   output      logic [lcg_ris_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output      logic                                  rsp_tuser    // [0] zero_bound_error
);
   import lcg_ris_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [WORD_W-1:0] gen_ff, gen_in;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [WORD_W-1:0] divisor_ff, divisor_in;
   logic              wide_ff, wide_in;
   logic              zero_ff, zero_in;
   logic [WORD_W-1:0] raw_ff, raw_in;
   logic [WORD_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_raw_ff, rsp_raw_in;
   logic [WORD_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_err_ff, rsp_err_in;
   logic [WORD_W-1:0] product;
   logic              req_fire;
   logic              out_free;
   div_ctrl_type      div_ctrl;
   div_status_type    div_status;
   logic [WORD_W-1:0] div_rem;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Low half of the product is the next generator value.
   assign product = sum_ff * LCG_MULTIPLIER;

   assign div_ctrl.start = (state_ff == ST_MUL) && !wide_ff;

   lcg_ris_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (product),
      .divisor   (divisor_ff),
      .status    (div_status),
      .remainder (div_rem)
   );

   // Sequencer: add, multiply, remainder if bound < 2^32, hand off; a zero bound only hands off.
   always_comb begin
      state_in   = state_ff;
      gen_in     = gen_ff;
      sum_in     = sum_ff;
      divisor_in = divisor_ff;
      wide_in    = wide_ff;
      zero_in    = zero_ff;
      raw_in     = raw_ff;
      idx_in     = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_raw_in   = rsp_raw_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               gen_in = csr_wdata;
            end
            if (req_fire) begin
               sum_in     = gen_in + LCG_INCREMENT;
               divisor_in = req_tdata[WORD_W-1:0];
               wide_in    = |req_tdata[BOUND_W-1:WORD_W];
               zero_in    = (req_tdata[BOUND_W-1:0] == '0);
               raw_in     = '0;
               idx_in     = '0;
               if (req_tdata[BOUND_W-1:0] == '0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            gen_in = product;
            raw_in = product;
            // A bound past 32 bits always exceeds the draw.
            if (wide_ff) begin
               idx_in   = product;
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               idx_in   = div_rem;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_raw_in   = raw_ff;
               rsp_idx_in   = idx_ff;
               rsp_hit_in   = !zero_ff && (idx_ff == '0);
               rsp_err_in   = zero_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff     <= sum_in;
      divisor_ff <= divisor_in;
      wide_ff    <= wide_in;
      zero_ff    <= zero_in;
      raw_ff     <= raw_in;
      idx_ff     <= idx_in;
      rsp_raw_ff <= rsp_raw_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_hit_ff, rsp_idx_ff, rsp_raw_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

`default_nettype wire

/* hdl/lcg_ris_divider.sv */
// ============================================================================
// LCG sampler remainder unit
// Restoring shift-subtract remainder, one dividend bit per cycle.
// ============================================================================
`default_nettype none

module lcg_ris_divider (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lcg_ris_pkg::div_ctrl_type          ctrl,
   input  wire logic [lcg_ris_pkg::WORD_W-1:0]     dividend,
   input  wire logic [lcg_ris_pkg::WORD_W-1:0]     divisor,
   output      lcg_ris_pkg::div_status_type        status,
   output      logic [lcg_ris_pkg::WORD_W-1:0]     remainder
);
   import lcg_ris_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    shift_ff, shift_in;
   logic [WORD_W-1:0]    divisor_ff, divisor_in;
   logic [WORD_W:0]      trial;
   logic [WORD_W:0]      diff;

   // Bring down the next dividend bit and try the subtraction.
   assign trial = {rem_ff, shift_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      if (ctrl.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         shift_in   = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         shift_in = {shift_ff[WORD_W-2:0], 1'b0};
         // Keep the difference only when it did not borrow.
         if (diff[WORD_W]) begin
            rem_in = trial[WORD_W-1:0];
         end else begin
            rem_in = diff[WORD_W-1:0];
         end
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
   end

   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire
